// File: hw/rtl/dq_pkg.sv
package dq_pkg;

  // number of cells in the chain
  localparam int CAPACITY = 16;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // request codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
  // spare codes, answered with status ok and value zero
  localparam logic [OP_W-1:0] OP_RSVD_A     = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B     = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // shift command broadcast to every cell
  typedef struct packed {
    logic              ins_front;
    logic              ins_back;
    logic              rem_front;
    logic              rem_back;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } cell_link_t;

endpackage

// File: hw/rtl/dq_in_if.sv
interface dq_in_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

// File: hw/rtl/dq_out_if.sv
interface dq_out_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// File: hw/rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words, built as a row of CAPACITY cells.
// The front element always sits in the first cell; the occupied cells form an
// unbroken run from there.
// in_chan carries a request (op, push_value); out_chan returns one word per
// request (result_value, status) with valid/ready handshaking on both sides.
// Push front and pop front shift every cell by one place together;
// push back fills the first free cell, pop back empties the last occupied one.
// Peek back is picked out by the cell whose right neighbour is empty.
// The result is registered and shows on out_chan in the cycle after the
// request is accepted. The queue takes one request per cycle, set by the single
// cell update per cycle, as long as the receiver keeps out_chan.ready high.
// When the receiver stalls the result word holds and in_chan.ready drops until
// it is taken; nothing is lost.
// Reset (rst_n low, synchronous) clears every cell's occupancy flag, leaving
// the queue empty; no clearing pass is needed.
// Pop or peek on empty gives value 0 with status empty; push on full is
// dropped with status full; codes 6 and 7 give value 0 with status ok.
module double_ended_queue (
  input  logic         clk,
  input  logic         rst_n,
  dq_in_if.sink        in_chan,
  dq_out_if.source     out_chan
);
  import dq_pkg::*;

  cell_cmd_t         cmd;
  cell_link_t        links   [CAPACITY];
  cell_link_t        left_l  [CAPACITY];
  cell_link_t        right_l [CAPACITY];
  logic [DATA_W-1:0] back_parts [CAPACITY];
  logic [DATA_W-1:0] back_value;

  logic              fire, empty, full;
  logic              out_valid_r;
  logic [DATA_W-1:0] result_r, result_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  // accept while the output word is free or being taken
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  assign empty = !links[0].valid;
  assign full  = links[CAPACITY-1].valid;

  // broadcast shift command
  always_comb begin
    cmd.ins_front = fire && (in_chan.op == OP_PUSH_FRONT) && !full;
    cmd.ins_back  = fire && (in_chan.op == OP_PUSH_BACK) && !full;
    cmd.rem_front = fire && (in_chan.op == OP_POP_FRONT) && !empty;
    cmd.rem_back  = fire && (in_chan.op == OP_POP_BACK) && !empty;
    cmd.value     = in_chan.push_value;
  end

  // neighbour wiring; the chain start feeds the pushed word in
  always_comb begin
    left_l[0].valid = 1'b1;
    left_l[0].data  = in_chan.push_value;
    for (int i = 1; i < CAPACITY; i++) begin
      left_l[i] = links[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      right_l[i] = links[i+1];
    end
    right_l[CAPACITY-1].valid = 1'b0;
    right_l[CAPACITY-1].data  = '0;
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_in   (left_l[g]),
      .right_in  (right_l[g]),
      .link_out  (links[g]),
      .back_data (back_parts[g])
    );
  end

  // only the last occupied cell contributes
  always_comb begin
    back_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_value = back_value | back_parts[i];
    end
  end

  // result word
  always_comb begin
    result_nxt = '0;
    status_nxt = ST_OK;
    case (in_chan.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          result_nxt = links[0].data;
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          result_nxt = back_value;
        end
      end
      default: begin
        result_nxt = '0;
        status_nxt = ST_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = result_r;
  assign out_chan.status       = status_r;
endmodule

// File: hw/rtl/dq_cell.sv
module dq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dq_pkg::cell_cmd_t  cmd,
  input  dq_pkg::cell_link_t left_in,
  input  dq_pkg::cell_link_t right_in,
  output dq_pkg::cell_link_t link_out,
  output logic [dq_pkg::DATA_W-1:0] back_data
);
  import dq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              is_last;

  // this cell holds the back element
  assign is_last = valid_r && !right_in.valid;

  // next contents from the command and the neighbours
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (cmd.ins_front) begin
      valid_nxt = left_in.valid;
      data_nxt  = left_in.data;
    end else if (cmd.ins_back) begin
      if (!valid_r && left_in.valid) begin
        valid_nxt = 1'b1;
        data_nxt  = cmd.value;
      end
    end else if (cmd.rem_front) begin
      valid_nxt = right_in.valid;
      data_nxt  = right_in.data;
    end else if (cmd.rem_back) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stored word
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link_out.valid = valid_r;
  assign link_out.data  = data_r;
  assign back_data      = is_last ? data_r : '0;
endmodule
